/* hdl/njbh_pkg.sv */
// ----------------------------------------------------------------------------
// Join handshake package
// Shared types and codes for the node join backoff handshake unit.
// ----------------------------------------------------------------------------
package njbh_pkg;

    // Join phase of the node.
    typedef enum logic [1:0] {
        PH_POWER   = 2'd0,
        PH_CONNECT = 2'd1,
        PH_RUN     = 2'd2
    } phase_t;

    // Message command codes.
    localparam logic [7:0] CMD_CONNECT = 8'd1;
    localparam logic [7:0] CMD_ACCEPT  = 8'd2;

    // Input item kinds.
    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_MSG  = 1'b1;

    // Role codes.
    localparam logic ROLE_MEMBER = 1'b0;
    localparam logic ROLE_LEADER = 1'b1;

    // Payload size of an accept message in bytes.
    localparam logic [1:0] ACCEPT_SIZE = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_ROLE            = 3'd0;
    localparam logic [2:0] REG_LEADER_ID       = 3'd1;
    localparam logic [2:0] REG_FIRST_MEMBER_ID = 3'd2;
    localparam logic [2:0] REG_MAX_RETRIES     = 3'd3;
    localparam logic [2:0] REG_FIRST_BACKOFF   = 3'd4;

    // One result item.
    typedef struct packed {
        logic [1:0]  join_phase;
        logic [15:0] node_id;
        logic [7:0]  send_data;
        logic [1:0]  send_size;
        logic [15:0] send_target;
        logic [7:0]  send_cmd;
        logic        send_valid;
    } result_t;

endpackage

/* hdl/node_join_backoff_handshake_unit.sv */
// ----------------------------------------------------------------------------
// Node join backoff handshake unit
// Runs the join handshake as member or leader and reports each step.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream (s_*) carries one item per transfer: s_tuser selects a
//   loop step (0) or a received message (1); s_tdata holds now_ticks,
//   msg_cmd and msg_data. Every accepted item produces exactly one result on
//   the output stream (m_*), holding any message to send, the node id and
//   the join phase after the item.
//   The result is registered and valid in the cycle after the input transfer.
//   Throughput is one item per cycle while the receiver keeps up: all state
//   updates are a subtract, an add, compares and selects feeding the result register.
//   The result register frees itself in the cycle it is taken, so a new
//   item is accepted while the current result is being consumed. When the
//   receiver stalls, the held result stays put and s_tready drops until it
//   is taken.
//   The APB port writes the five configuration registers at byte addresses
//   0, 4, 8, 12 and 16; it must only be written while the unit is idle.
//   Synchronous reset (aresetn low) returns the phase to power, clears all
//   handshake state, empties the result register and restores register
//   defaults: member role, leader id 1, member id 2, 8 retries, backoff 10.
// ----------------------------------------------------------------------------
module node_join_backoff_handshake_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // now_ticks[31:0], msg_cmd[39:32], msg_data[47:40]
    input  logic        s_tuser,   // mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // send_valid[0], send_cmd[8:1], send_target[24:9],
                                   // send_size[26:25], send_data[34:27],
                                   // node_id[50:35], join_phase[52:51], zero[55:53]
);

    // Configuration registers.
    logic        role_reg;
    logic [15:0] leader_id_reg;
    logic [7:0]  first_member_id_reg;
    logic [3:0]  max_retries_reg;
    logic [15:0] first_backoff_reg;

    // Handshake state.
    njbh_pkg::phase_t phase_reg, phase_next;
    logic        accepted_reg, accepted_next;
    logic        waiting_reg, waiting_next;
    logic        pending_reg, pending_next;
    logic [3:0]  retries_reg, retries_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] backoff_reg, backoff_next;
    logic [15:0] own_id_reg, own_id_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    njbh_pkg::result_t result_reg, result_next;

    logic        in_fire;
    logic        cfg_write;
    logic [2:0]  cfg_idx;
    logic        in_mode;
    logic [31:0] in_now;
    logic [7:0]  in_cmd;
    logic [7:0]  in_data;
    logic [31:0] elapsed;

    assign in_mode = s_tuser;
    assign in_now  = s_tdata[31:0];
    assign in_cmd  = s_tdata[39:32];
    assign in_data = s_tdata[47:40];

    // The result register is free when empty or being taken this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Configuration write and read decode.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            njbh_pkg::REG_ROLE:            prdata = {31'd0, role_reg};
            njbh_pkg::REG_LEADER_ID:       prdata = {16'd0, leader_id_reg};
            njbh_pkg::REG_FIRST_MEMBER_ID: prdata = {24'd0, first_member_id_reg};
            njbh_pkg::REG_MAX_RETRIES:     prdata = {28'd0, max_retries_reg};
            njbh_pkg::REG_FIRST_BACKOFF:   prdata = {16'd0, first_backoff_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_reg            <= njbh_pkg::ROLE_MEMBER;
            leader_id_reg       <= 16'd1;
            first_member_id_reg <= 8'd2;
            max_retries_reg     <= 4'd8;
            first_backoff_reg   <= 16'd10;
        end else if (cfg_write) begin
            case (cfg_idx)
                njbh_pkg::REG_ROLE:            role_reg            <= pwdata[0];
                njbh_pkg::REG_LEADER_ID:       leader_id_reg       <= pwdata[15:0];
                njbh_pkg::REG_FIRST_MEMBER_ID: first_member_id_reg <= pwdata[7:0];
                njbh_pkg::REG_MAX_RETRIES:     max_retries_reg     <= pwdata[3:0];
                njbh_pkg::REG_FIRST_BACKOFF:   first_backoff_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Ticks since the wait was armed, modulo 2^32.
    assign elapsed = in_now - start_time_reg;

    // Next state and result of the current item.
    always_comb begin
        phase_next      = phase_reg;
        accepted_next   = accepted_reg;
        waiting_next    = waiting_reg;
        pending_next    = pending_reg;
        retries_next    = retries_reg;
        start_time_next = start_time_reg;
        backoff_next    = backoff_reg;
        own_id_next     = own_id_reg;
        result_next     = '0;

        if (role_reg == njbh_pkg::ROLE_MEMBER) begin
            if (in_mode == njbh_pkg::MODE_STEP) begin
                case (phase_reg)
                    njbh_pkg::PH_POWER: begin
                        phase_next = njbh_pkg::PH_CONNECT;
                    end
                    njbh_pkg::PH_CONNECT: begin
                        if (accepted_reg) begin
                            phase_next = njbh_pkg::PH_RUN;
                        end else if (retries_reg < max_retries_reg) begin
                            if (!waiting_reg) begin
                                // Arm the wait; the second wait loads the first backoff.
                                waiting_next    = 1'b1;
                                start_time_next = in_now;
                                if (retries_reg == 4'd1) begin
                                    backoff_next = {16'd0, first_backoff_reg};
                                end
                            end else if (elapsed > backoff_reg) begin
                                // Backoff expired: send a connect request.
                                backoff_next            = {backoff_reg[30:0], 1'b0};
                                waiting_next            = 1'b0;
                                retries_next            = retries_reg + 4'd1;
                                result_next.send_valid  = 1'b1;
                                result_next.send_cmd    = njbh_pkg::CMD_CONNECT;
                                result_next.send_target = leader_id_reg;
                            end
                        end
                    end
                    njbh_pkg::PH_RUN: begin
                    end
                    default: begin
                        // Undefined phase code recovers into connect.
                        phase_next = njbh_pkg::PH_CONNECT;
                    end
                endcase
            end else if (in_cmd == njbh_pkg::CMD_ACCEPT) begin
                accepted_next = 1'b1;
                own_id_next   = {8'd0, in_data};
            end
        end else begin
            if (in_mode == njbh_pkg::MODE_STEP) begin
                if (phase_reg == njbh_pkg::PH_POWER) begin
                    own_id_next = leader_id_reg;
                    phase_next  = njbh_pkg::PH_RUN;
                end else if (phase_reg == njbh_pkg::PH_RUN && pending_reg) begin
                    // Answer the pending connect request.
                    result_next.send_valid = 1'b1;
                    result_next.send_cmd   = njbh_pkg::CMD_ACCEPT;
                    result_next.send_size  = njbh_pkg::ACCEPT_SIZE;
                    result_next.send_data  = first_member_id_reg;
                    pending_next           = 1'b0;
                end
            end else if (in_cmd == njbh_pkg::CMD_CONNECT) begin
                pending_next = 1'b1;
            end
        end

        result_next.node_id    = own_id_next;
        result_next.join_phase = phase_next;
    end

    // Output valid: set by an accepted item, cleared when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // State and result registers advance on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= njbh_pkg::PH_POWER;
            accepted_reg   <= 1'b0;
            waiting_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            retries_reg    <= 4'd0;
            start_time_reg <= 32'd0;
            backoff_reg    <= 32'd0;
            own_id_reg     <= 16'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_fire) begin
                phase_reg      <= phase_next;
                accepted_reg   <= accepted_next;
                waiting_reg    <= waiting_next;
                pending_reg    <= pending_next;
                retries_reg    <= retries_next;
                start_time_reg <= start_time_next;
                backoff_reg    <= backoff_next;
                own_id_reg     <= own_id_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, result_reg};

    // A stalled result blocks new input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    // A message in a result is always a connect or an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
            (m_tdata[8:1] == njbh_pkg::CMD_CONNECT || m_tdata[8:1] == njbh_pkg::CMD_ACCEPT))
        else $error("unknown command in result");

    // Each retry step goes out with a connect request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && retries_next != retries_reg) |=>
            (m_tvalid && m_tdata[0] && m_tdata[8:1] == njbh_pkg::CMD_CONNECT))
        else $error("retry counted without connect request");

    // An accept is only sent by a leader in run phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && result_next.send_cmd == njbh_pkg::CMD_ACCEPT) |->
            (role_reg == njbh_pkg::ROLE_LEADER && phase_reg == njbh_pkg::PH_RUN))
        else $error("accept sent outside leader run phase");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Join handshake unit testbench
// Drives the node join backoff handshake unit with directed and random
// requests over its stream input and checks every report on its stream
// output against a cycle-free model of the member and leader handshake.
// The configuration port is written between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;

    // Addresses past the last register; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_LO   = 3'd5;
    localparam logic [2:0] REG_SPARE_HI   = 3'd7;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         HOLD_AT        = 1400;
    localparam int         HOLD_CYCLES    = 60;

    // Tracks the join state of the unit and the reports it must produce.
    class join_tracker;
        logic        role;
        logic [15:0] leader_id;
        logic [7:0]  first_member_id;
        logic [3:0]  max_retries;
        logic [15:0] first_backoff;

        njbh_pkg::phase_t phase;
        bit          accepted;
        bit          waiting;
        bit          connect_seen;
        logic [3:0]  retries;
        logic [31:0] start_time;
        logic [31:0] backoff;
        logic [15:0] own_id;

        njbh_pkg::result_t step_reports[$];
        int          errors;
        int          reports_checked;
        int          connects_sent;
        int          accepts_sent;

        function new();
            role            = njbh_pkg::ROLE_MEMBER;
            leader_id       = 16'd1;
            first_member_id = 8'd2;
            max_retries     = 4'd8;
            first_backoff   = 16'd10;
            phase           = njbh_pkg::PH_POWER;
            accepted        = 1'b0;
            waiting         = 1'b0;
            connect_seen    = 1'b0;
            retries         = '0;
            start_time      = '0;
            backoff         = '0;
            own_id          = '0;
            errors          = 0;
            reports_checked = 0;
            connects_sent   = 0;
            accepts_sent    = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [31:0] value);
            case (index)
                njbh_pkg::REG_ROLE:            role = value[0];
                njbh_pkg::REG_LEADER_ID:       leader_id = value[15:0];
                njbh_pkg::REG_FIRST_MEMBER_ID: first_member_id = value[7:0];
                njbh_pkg::REG_MAX_RETRIES:     max_retries = value[3:0];
                njbh_pkg::REG_FIRST_BACKOFF:   first_backoff = value[15:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted request to the join state and queues its report.
        function void advance_join(logic mode, logic [31:0] now, logic [7:0] cmd,
                                   logic [7:0] data);
            njbh_pkg::result_t rep;
            logic [31:0]       elapsed;
            rep = '0;
            if (role == njbh_pkg::ROLE_MEMBER) begin
                if (mode == njbh_pkg::MODE_STEP) begin
                    case (phase)
                        njbh_pkg::PH_POWER: phase = njbh_pkg::PH_CONNECT;
                        njbh_pkg::PH_CONNECT: begin
                            if (accepted) begin
                                phase = njbh_pkg::PH_RUN;
                            end else if (retries < max_retries) begin
                                elapsed = now - start_time;
                                if (!waiting) begin
                                    // Arm the wait; the second one loads the first backoff.
                                    waiting    = 1'b1;
                                    start_time = now;
                                    if (retries == 4'd1)
                                        backoff = {16'd0, first_backoff};
                                end else if (elapsed > backoff) begin
                                    backoff           = backoff << 1;
                                    waiting           = 1'b0;
                                    retries           = retries + 4'd1;
                                    rep.send_valid    = 1'b1;
                                    rep.send_cmd      = njbh_pkg::CMD_CONNECT;
                                    rep.send_target   = leader_id;
                                    connects_sent++;
                                end
                            end
                        end
                        njbh_pkg::PH_RUN: ;
                        default: phase = njbh_pkg::PH_CONNECT;
                    endcase
                end else if (cmd == njbh_pkg::CMD_ACCEPT) begin
                    accepted = 1'b1;
                    own_id   = {8'd0, data};
                end
            end else begin
                if (mode == njbh_pkg::MODE_STEP) begin
                    if (phase == njbh_pkg::PH_POWER) begin
                        own_id = leader_id;
                        phase  = njbh_pkg::PH_RUN;
                    end else if (phase == njbh_pkg::PH_RUN && connect_seen) begin
                        // Answer the waiting connect message with an accept.
                        rep.send_valid  = 1'b1;
                        rep.send_cmd    = njbh_pkg::CMD_ACCEPT;
                        rep.send_target = 16'd0;
                        rep.send_size   = njbh_pkg::ACCEPT_SIZE;
                        rep.send_data   = first_member_id;
                        connect_seen    = 1'b0;
                        accepts_sent++;
                    end
                end else if (cmd == njbh_pkg::CMD_CONNECT) begin
                    connect_seen = 1'b1;
                end
            end
            rep.node_id    = own_id;
            rep.join_phase = phase;
            step_reports.push_back(rep);
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
            end
        endfunction

        // Compares one report from the unit with the oldest one predicted.
        function void check_report(logic [55:0] word);
            njbh_pkg::result_t want;
            njbh_pkg::result_t got;
            reports_checked++;
            if (step_reports.size() == 0) begin
                errors++;
                $display("%0t: report with none predicted, expected nothing, actual 0x%0h",
                         $time, word);
                return;
            end
            want = step_reports.pop_front();
            got  = njbh_pkg::result_t'(word[52:0]);
            compare_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
            compare_field("send_cmd", 32'(want.send_cmd), 32'(got.send_cmd));
            compare_field("send_target", 32'(want.send_target), 32'(got.send_target));
            compare_field("send_size", 32'(want.send_size), 32'(got.send_size));
            compare_field("send_data", 32'(want.send_data), 32'(got.send_data));
            compare_field("node_id", 32'(want.node_id), 32'(got.node_id));
            compare_field("join_phase", 32'(want.join_phase), 32'(got.join_phase));
            compare_field("padding", 32'd0, 32'(word[55:53]));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // now_ticks[31:0], msg_cmd[39:32], msg_data[47:40]
    logic        s_tuser = 1'b0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // send_valid[0], send_cmd[8:1], send_target[24:9],
                                   // send_size[26:25], send_data[34:27],
                                   // node_id[50:35], join_phase[52:51], zero[55:53]

    join_tracker tracker;
    int          items_sent = 0;
    int          src_gap_pct = 13;
    int          sink_stall_pct = 81;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet = 0;
    logic [31:0] tick = '0;

    node_join_backoff_handshake_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: check each taken report, stall at random, and once hold
    // off long enough for the unit to back up into its input.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_report(m_tdata);
        if (hold_left == 0 && !hold_done && tracker.reports_checked >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    initial begin
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Register write: a setup phase, then an access phase.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_register(index, value);
    endtask

    // Offers one request and waits until the unit takes it.
    task automatic offer_item(input logic mode, input logic [31:0] now,
                              input logic [7:0] cmd, input logic [7:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {data, cmd, now};
        do @(posedge aclk); while (!s_tready);
        tracker.advance_join(mode, now, cmd, data);
        items_sent++;
        if (items_sent < 620) begin
            src_gap_pct    = 13;
            sink_stall_pct = 81;
        end else if (items_sent < 1240) begin
            src_gap_pct    = 81;
            sink_stall_pct = 13;
        end else begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
        end
        // Each idle cycle is drawn on its own, so the idle share matches the rate.
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Stops offering until every predicted report has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.step_reports.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Member in connect: mostly loop steps whose tick lands near the last tick,
    // near the end of the current backoff or anywhere, mixed with stray and foreign messages.
    task automatic member_connect_burst(input int count);
        logic [31:0] now;
        logic [7:0]  cmd;
        int          pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                pick = $urandom_range(9);
                if (pick < 4)
                    now = tick + $urandom_range(15);
                else if (pick < 7)
                    now = tracker.start_time + tracker.backoff + $urandom_range(2) - 1;
                else if (pick < 9)
                    now = tick + $urandom_range(tracker.backoff);
                else
                    now = $urandom;
                tick = now;
                offer_item(njbh_pkg::MODE_STEP, now, 8'($urandom), 8'($urandom));
            end else begin
                cmd = 8'($urandom);
                if (cmd == njbh_pkg::CMD_ACCEPT)
                    cmd = njbh_pkg::CMD_CONNECT;
                offer_item(njbh_pkg::MODE_MSG, $urandom, cmd, 8'($urandom));
            end
        end
    endtask

    // Run phase for either role: loop steps, connect and accept messages, noise.
    task automatic run_burst(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                offer_item(njbh_pkg::MODE_STEP, $urandom, 8'($urandom), 8'($urandom));
            else if (pick < 75)
                offer_item(njbh_pkg::MODE_MSG, $urandom, njbh_pkg::CMD_CONNECT,
                           8'($urandom));
            else if (pick < 88)
                offer_item(njbh_pkg::MODE_MSG, $urandom, njbh_pkg::CMD_ACCEPT,
                           8'($urandom));
            else
                offer_item(njbh_pkg::MODE_MSG, $urandom, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Member with extreme settings and a short retry limit.
        write_reg(njbh_pkg::REG_ROLE, 32'(njbh_pkg::ROLE_MEMBER));
        write_reg(njbh_pkg::REG_LEADER_ID, 32'h0000_FFFF);
        write_reg(njbh_pkg::REG_FIRST_MEMBER_ID, 32'd0);
        write_reg(njbh_pkg::REG_MAX_RETRIES, 32'd2);
        write_reg(njbh_pkg::REG_FIRST_BACKOFF, 32'd0);
        write_reg(njbh_pkg::REG_FIRST_BACKOFF, 32'h0000_FFFF);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0000);

        // Unknown commands and a connect message are ignored in power.
        offer_item(njbh_pkg::MODE_MSG, 32'd0, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_MSG, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        offer_item(njbh_pkg::MODE_MSG, 32'd0, njbh_pkg::CMD_CONNECT, 8'h5A);
        // Enter connect, arm near the top of the tick range, wrap past zero.
        offer_item(njbh_pkg::MODE_STEP, 32'hFFFF_FFF0, 8'hFF, 8'hFF);
        offer_item(njbh_pkg::MODE_STEP, 32'hFFFF_FFF0, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_STEP, 32'hFFFF_FFF0, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_STEP, 32'd2, 8'd0, 8'd0);
        // Second wait loads the backoff; equal elapsed time does not send.
        offer_item(njbh_pkg::MODE_STEP, 32'd3, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_STEP, 32'd65538, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_STEP, 32'd65539, 8'd0, 8'd0);
        // Retry limit reached: nothing more goes out.
        offer_item(njbh_pkg::MODE_STEP, 32'hFFFF_FFFF, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_MSG, 32'd0, njbh_pkg::CMD_CONNECT, 8'hFF);
        tick = 32'd65539;
        settle();

        // Lift the retry limit and let the backoff keep doubling.
        write_reg(njbh_pkg::REG_MAX_RETRIES, 32'd15);
        write_reg(njbh_pkg::REG_LEADER_ID, $urandom_range(16'hFFFE, 1));
        member_connect_burst(300);
        settle();

        // Leader in connect does nothing but notes a connect message.
        write_reg(njbh_pkg::REG_ROLE, 32'(njbh_pkg::ROLE_LEADER));
        offer_item(njbh_pkg::MODE_STEP, $urandom, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_MSG, $urandom, njbh_pkg::CMD_CONNECT, 8'd0);
        offer_item(njbh_pkg::MODE_STEP, $urandom, 8'd0, 8'd0);
        settle();
        // Back to member: the accept moves it to run on the next loop step.
        write_reg(njbh_pkg::REG_ROLE, 32'(njbh_pkg::ROLE_MEMBER));
        offer_item(njbh_pkg::MODE_MSG, $urandom, njbh_pkg::CMD_ACCEPT, 8'h00);
        offer_item(njbh_pkg::MODE_STEP, $urandom, 8'd0, 8'd0);
        offer_item(njbh_pkg::MODE_MSG, $urandom, njbh_pkg::CMD_ACCEPT, 8'hFF);
        settle();
        // The leader answers the connect message it saw while connecting.
        write_reg(njbh_pkg::REG_ROLE, 32'(njbh_pkg::ROLE_LEADER));
        write_reg(njbh_pkg::REG_FIRST_MEMBER_ID, 32'd255);
        offer_item(njbh_pkg::MODE_STEP, $urandom, 8'd0, 8'd0);
        run_burst(600);
        settle();

        // Member in run with the retry limit and backoff at their minimum.
        write_reg(njbh_pkg::REG_ROLE, 32'(njbh_pkg::ROLE_MEMBER));
        write_reg(njbh_pkg::REG_MAX_RETRIES, 32'd0);
        write_reg(njbh_pkg::REG_FIRST_BACKOFF, 32'd0);
        run_burst(300);
        settle();

        write_reg(njbh_pkg::REG_ROLE, 32'(njbh_pkg::ROLE_LEADER));
        write_reg(njbh_pkg::REG_FIRST_MEMBER_ID, $urandom_range(254, 1));
        write_reg(njbh_pkg::REG_LEADER_ID, $urandom);
        run_burst(630);

        settle();
        repeat (4) @(posedge aclk);
        $display("Covered %0d requests: member backoff and retry limit,", items_sent);
        $display("leader answers and role changes; connects %0d, accepts %0d, %0d checked.",
                 tracker.connects_sent, tracker.accepts_sent, tracker.reports_checked);
        if (tracker.errors == 0 && tracker.step_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* node_join_backoff_handshake_unit.f */
hdl/njbh_pkg.sv
hdl/node_join_backoff_handshake_unit.sv
verif/tb_top.sv
